// ----- sv/prt_pkg.sv -----
// ----------------------------------------------------------------------------
// prt_pkg: shared types and constants of the point rigid transform
// widths of the fixed-point datapath, register map and item payloads
// ----------------------------------------------------------------------------
package prt_pkg;

    // coordinate and quaternion formats
    localparam int COORD_W   = 32;
    localparam int QUAT_W    = 16;
    localparam int QUAT_FRAC = 14;
    localparam int FRAC_SH   = 2 * QUAT_FRAC;

    // rotation matrix entries: 1 - 2(a+b) of squares needs two extra bits
    localparam int MAT_W    = 2 * QUAT_W + 2;
    localparam int SPLIT_W  = MAT_W / 2;
    localparam int LO_PP_W  = SPLIT_W + 1 + COORD_W;
    localparam int HI_PP_W  = MAT_W - SPLIT_W + COORD_W;
    localparam int PROD_W   = MAT_W + COORD_W;
    localparam int PAIR_W   = PROD_W + 1;
    localparam int ACC_W    = PROD_W + 2;
    localparam int RND_W    = ACC_W - FRAC_SH;
    localparam int SUM_W    = RND_W + 1;

    // pipeline stages, input capture through output register
    localparam int PIPE_DEPTH = 7;

    // register map, byte address 4*index
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_TRANS_X = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_TRANS_Y = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_TRANS_Z = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_QUAT_X  = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_QUAT_Y  = REG_IDX_W'(4);
    localparam logic [REG_IDX_W-1:0] REG_QUAT_Z  = REG_IDX_W'(5);
    localparam logic [REG_IDX_W-1:0] REG_QUAT_W  = REG_IDX_W'(6);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [QUAT_W-1:0]  t_quat;
    typedef logic signed [MAT_W-1:0]   t_mat;

    localparam t_quat  QUAT_ONE  = t_quat'(1) <<< QUAT_FRAC;
    localparam t_coord COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      last_in;
    } t_point_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      last_out;
        logic                      overflow;
    } t_point_out;

endpackage

// ----- sv/point_rigid_transform_unit.sv -----
// ----------------------------------------------------------------------------
// point_rigid_transform_unit: fixed-point rigid-body point transform
// rotates each Q16.16 point by the matrix of a configured Q2.14 quaternion,
// adds the configured translation and saturates the result
// ----------------------------------------------------------------------------
// One item is accepted and one result item leaves per clock while the output
// side does not stall; each item passes the stages capture, align, partial
// products, product merge, pair sums, rounding, translate and saturate.
// Throughput is one item per clock unless the output stalls; the nine
// 34x32 matrix by point products are each split into two narrow partial
// products so that every stage holds about one multiplier or one wide add.
// The rotation matrix is derived from the quaternion registers by two
// register stages of its own and is ready before an item accepted after the
// write reaches the multipliers. Registers: trans_x/y/z at 0x00/0x04/0x08
// (32 bit signed), quat_x/y/z/w at 0x0c/0x10/0x14/0x18 (16 bit signed, read
// back sign extended); writes elsewhere are dropped. Reset gives the identity
// rotation and zero translation. Rounding is half up, the quaternion is never
// normalized, and the overflow flag marks an item with any clamped coordinate.
// ----------------------------------------------------------------------------
module point_rigid_transform_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // point input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  prt_pkg::t_point_in             i_in_data,
    // transformed point output channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output prt_pkg::t_point_out            o_out_data,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [prt_pkg::ADDR_W-1:0]     paddr,
    input  logic [prt_pkg::DATA_W-1:0]     pwdata,
    output logic [prt_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);
    import prt_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    t_coord r_trans [3];
    t_quat  r_quat_x, r_quat_y, r_quat_z, r_quat_w;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trans[0] <= '0;
            r_trans[1] <= '0;
            r_trans[2] <= '0;
            r_quat_x   <= '0;
            r_quat_y   <= '0;
            r_quat_z   <= '0;
            r_quat_w   <= QUAT_ONE;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_TRANS_X: r_trans[0] <= t_coord'(pwdata[COORD_W-1:0]);
                REG_TRANS_Y: r_trans[1] <= t_coord'(pwdata[COORD_W-1:0]);
                REG_TRANS_Z: r_trans[2] <= t_coord'(pwdata[COORD_W-1:0]);
                REG_QUAT_X:  r_quat_x   <= t_quat'(pwdata[QUAT_W-1:0]);
                REG_QUAT_Y:  r_quat_y   <= t_quat'(pwdata[QUAT_W-1:0]);
                REG_QUAT_Z:  r_quat_z   <= t_quat'(pwdata[QUAT_W-1:0]);
                REG_QUAT_W:  r_quat_w   <= t_quat'(pwdata[QUAT_W-1:0]);
                default: ;
            endcase
        end
    end

    // read back, quaternion parts sign extended
    always_comb begin
        case (cfg_idx)
            REG_TRANS_X: prdata = DATA_W'(r_trans[0]);
            REG_TRANS_Y: prdata = DATA_W'(r_trans[1]);
            REG_TRANS_Z: prdata = DATA_W'(r_trans[2]);
            REG_QUAT_X:  prdata = DATA_W'(r_quat_x);
            REG_QUAT_Y:  prdata = DATA_W'(r_quat_y);
            REG_QUAT_Z:  prdata = DATA_W'(r_quat_z);
            REG_QUAT_W:  prdata = DATA_W'(r_quat_w);
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // rotation matrix, two free-running register stages off the config
    // ------------------------------------------------------------------
    logic signed [2*QUAT_W-1:0] r_qxx, r_qyy, r_qzz, r_qxy, r_qxz, r_qyz;
    logic signed [2*QUAT_W-1:0] r_qxw, r_qyw, r_qzw;
    t_mat                       r_mat [3][3];

    localparam t_mat MAT_ONE = t_mat'(1) <<< FRAC_SH;

    // quaternion cross products, exact in 32 bits
    always_ff @(posedge i_clk) begin
        r_qxx <= (2*QUAT_W)'(r_quat_x) * (2*QUAT_W)'(r_quat_x);
        r_qyy <= (2*QUAT_W)'(r_quat_y) * (2*QUAT_W)'(r_quat_y);
        r_qzz <= (2*QUAT_W)'(r_quat_z) * (2*QUAT_W)'(r_quat_z);
        r_qxy <= (2*QUAT_W)'(r_quat_x) * (2*QUAT_W)'(r_quat_y);
        r_qxz <= (2*QUAT_W)'(r_quat_x) * (2*QUAT_W)'(r_quat_z);
        r_qyz <= (2*QUAT_W)'(r_quat_y) * (2*QUAT_W)'(r_quat_z);
        r_qxw <= (2*QUAT_W)'(r_quat_x) * (2*QUAT_W)'(r_quat_w);
        r_qyw <= (2*QUAT_W)'(r_quat_y) * (2*QUAT_W)'(r_quat_w);
        r_qzw <= (2*QUAT_W)'(r_quat_z) * (2*QUAT_W)'(r_quat_w);
    end

    // standard matrix, entries carry 2*QUAT_FRAC fraction bits
    always_ff @(posedge i_clk) begin
        r_mat[0][0] <= MAT_ONE - ((t_mat'(r_qyy) + t_mat'(r_qzz)) <<< 1);
        r_mat[0][1] <= (t_mat'(r_qxy) - t_mat'(r_qzw)) <<< 1;
        r_mat[0][2] <= (t_mat'(r_qxz) + t_mat'(r_qyw)) <<< 1;
        r_mat[1][0] <= (t_mat'(r_qxy) + t_mat'(r_qzw)) <<< 1;
        r_mat[1][1] <= MAT_ONE - ((t_mat'(r_qxx) + t_mat'(r_qzz)) <<< 1);
        r_mat[1][2] <= (t_mat'(r_qyz) - t_mat'(r_qxw)) <<< 1;
        r_mat[2][0] <= (t_mat'(r_qxz) - t_mat'(r_qyw)) <<< 1;
        r_mat[2][1] <= (t_mat'(r_qyz) + t_mat'(r_qxw)) <<< 1;
        r_mat[2][2] <= MAT_ONE - ((t_mat'(r_qxx) + t_mat'(r_qyy)) <<< 1);
    end

    // ------------------------------------------------------------------
    // pipeline control: a stage moves when it is empty or its successor moves
    // ------------------------------------------------------------------
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] stg_en;

    always_comb begin
        stg_en[PIPE_DEPTH-1] = !r_vld[PIPE_DEPTH-1] || i_out_ready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = stg_en[0];
    assign o_out_valid = r_vld[PIPE_DEPTH-1];

    // last marker rides alongside the item
    logic [PIPE_DEPTH-2:0] r_last;

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_last[0] <= i_in_data.last_in;
        end
        for (int k = 1; k < PIPE_DEPTH - 1; k++) begin
            if (stg_en[k]) begin
                r_last[k] <= r_last[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stages 0 and 1: capture and align with the matrix stages
    // ------------------------------------------------------------------
    t_coord r_pt0 [3];
    t_coord r_pt1 [3];

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_pt0[0] <= i_in_data.point_x;
            r_pt0[1] <= i_in_data.point_y;
            r_pt0[2] <= i_in_data.point_z;
        end
        if (stg_en[1]) begin
            r_pt1 <= r_pt0;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: partial products, matrix entry split into low and high halves
    // ------------------------------------------------------------------
    logic signed [LO_PP_W-1:0] r_pp_lo [3][3];
    logic signed [HI_PP_W-1:0] r_pp_hi [3][3];

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_pp_lo[r][c] <= LO_PP_W'($signed({1'b0, r_mat[r][c][SPLIT_W-1:0]}))
                                   * LO_PP_W'(r_pt1[c]);
                    r_pp_hi[r][c] <= HI_PP_W'($signed(r_mat[r][c][MAT_W-1:SPLIT_W]))
                                   * HI_PP_W'(r_pt1[c]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 3: merge halves into full products
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] r_prod [3][3];

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= (PROD_W'(r_pp_hi[r][c]) <<< SPLIT_W)
                                  + PROD_W'(r_pp_lo[r][c]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 4: row sums in two halves, rounding constant folded in
    // ------------------------------------------------------------------
    localparam logic signed [PAIR_W-1:0] RND_HALF = PAIR_W'(1) <<< (FRAC_SH - 1);

    logic signed [PAIR_W-1:0] r_pair [3];
    logic signed [PAIR_W-1:0] r_part [3];

    always_ff @(posedge i_clk) begin
        if (stg_en[4]) begin
            for (int r = 0; r < 3; r++) begin
                r_pair[r] <= PAIR_W'(r_prod[r][0]) + PAIR_W'(r_prod[r][1]);
                r_part[r] <= PAIR_W'(r_prod[r][2]) + RND_HALF;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 5: full row sum, floor shift back to coordinate format
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] s5_acc [3];
    logic signed [RND_W-1:0] r_rnd  [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            s5_acc[r] = ACC_W'(r_pair[r]) + ACC_W'(r_part[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[5]) begin
            for (int r = 0; r < 3; r++) begin
                r_rnd[r] <= $signed(s5_acc[r][ACC_W-1:FRAC_SH]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 6: add translation, clamp, output register
    // ------------------------------------------------------------------
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(COORD_MAX);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(COORD_MIN);

    logic signed [SUM_W-1:0] s6_sum [3];
    t_coord                  s6_val [3];
    logic [2:0]              s6_ovf;
    t_point_out              r_out;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            s6_sum[r] = SUM_W'(r_rnd[r]) + SUM_W'(r_trans[r]);
            if (s6_sum[r] > SUM_MAX) begin
                s6_val[r] = COORD_MAX;
                s6_ovf[r] = 1'b1;
            end else if (s6_sum[r] < SUM_MIN) begin
                s6_val[r] = COORD_MIN;
                s6_ovf[r] = 1'b1;
            end else begin
                s6_val[r] = s6_sum[r][COORD_W-1:0];
                s6_ovf[r] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[6]) begin
            r_out.out_x    <= s6_val[0];
            r_out.out_y    <= s6_val[1];
            r_out.out_z    <= s6_val[2];
            r_out.last_out <= r_last[PIPE_DEPTH-2];
            r_out.overflow <= |s6_ovf;
        end
    end

    assign o_out_data = r_out;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // input back-pressure only when every stage is full and the output stalls
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> ((&r_vld) && !i_out_ready))
        else $error("input stalled while the pipeline has room");

    // a flagged item has at least one clamped coordinate
    a_ovf_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.overflow) |->
            (o_out_data.out_x == COORD_MAX || o_out_data.out_x == COORD_MIN ||
             o_out_data.out_y == COORD_MAX || o_out_data.out_y == COORD_MIN ||
             o_out_data.out_z == COORD_MAX || o_out_data.out_z == COORD_MIN))
        else $error("overflow flagged without a clamped coordinate");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("items left in flight after reset");

    // an item accepted into an empty pipeline leaves after the full depth
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (r_vld == '0)) |=> ##6 r_vld[PIPE_DEPTH-1])
        else $error("item did not reach the output register in time");

endmodule

// ----- tb/point_rigid_transform_unit_test.sv -----
// ----------------------------------------------------------------------------
// point_rigid_transform_unit_test: self-checking bench of the point transform
// streams framed point lists through the unit under a series of poses, predicts
// every rotated, translated and saturated point and compares it field by field
// ----------------------------------------------------------------------------
module point_rigid_transform_unit_test;
    import prt_pkg::*;

    // wide enough for a 34-bit matrix entry times a 32-bit point, summed
    typedef logic signed [79:0] t_wide;

    localparam t_wide ROUND_HALF = t_wide'(1) <<< (FRAC_SH - 1);
    localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_IDX_W'(7);

    localparam int RANDOM_POSES   = 14;
    localparam int ITEMS_PER_POSE = 125;
    localparam int HOLD_CYCLES    = 40;
    localparam int DRAIN_LIMIT    = 6000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_point_in             i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_point_out            o_out_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [DATA_W-1:0]     pwdata = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    point_rigid_transform_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // bench copy of the pose registers, reset values: identity, no shift
    t_coord pose_shift_x = '0;
    t_coord pose_shift_y = '0;
    t_coord pose_shift_z = '0;
    t_quat  pose_quat_x  = '0;
    t_quat  pose_quat_y  = '0;
    t_quat  pose_quat_z  = '0;
    t_quat  pose_quat_w  = QUAT_ONE;

    t_point_in  pending_points [$];    // items waiting to be offered
    t_point_out expected_points [$];   // predicted results, oldest first

    logic idle_enable = 1'b1;          // random gaps on both channels
    int   hold_requests = 0;           // bumped to ask for a long receiver hold
    int   hold_served = 0;
    int   send_wait = 0;
    int   ready_wait = 0;

    int errors = 0;
    int points_accepted = 0;
    int results_checked = 0;
    int clamped_results = 0;
    int lists_closed = 0;
    int poses_loaded = 0;

    // ------------------------------------------------------------------------
    // transform prediction
    // ------------------------------------------------------------------------

    // one matrix row times the point, rounded half up to the coordinate format,
    // plus the translation; kept wide so that saturation can be judged after
    function automatic t_wide row_sum(input t_wide m0, input t_wide m1, input t_wide m2,
                                      input t_point_in p, input t_coord shift);
        t_wide acc;
        acc = m0 * t_wide'(p.point_x) + m1 * t_wide'(p.point_y)
            + m2 * t_wide'(p.point_z);
        acc = (acc + ROUND_HALF) >>> FRAC_SH;
        return acc + t_wide'(shift);
    endfunction

    function automatic t_coord clamp_coord(input t_wide v);
        if (v > t_wide'(COORD_MAX))
            return COORD_MAX;
        if (v < t_wide'(COORD_MIN))
            return COORD_MIN;
        return t_coord'(v);
    endfunction

    function automatic t_point_out transform_point(input t_point_in p);
        t_wide qx, qy, qz, qw, one;
        t_wide xx, yy, zz, xy, xz, yz, xw, yw, zw;
        t_wide sum_x, sum_y, sum_z;
        t_point_out r;
        qx  = t_wide'(pose_quat_x);
        qy  = t_wide'(pose_quat_y);
        qz  = t_wide'(pose_quat_z);
        qw  = t_wide'(pose_quat_w);
        one = t_wide'(1) <<< FRAC_SH;
        xx = qx * qx; yy = qy * qy; zz = qz * qz;
        xy = qx * qy; xz = qx * qz; yz = qy * qz;
        xw = qx * qw; yw = qy * qw; zw = qz * qw;
        // matrix entries carry twice the quaternion fraction bits, never normalized
        sum_x = row_sum(one - 2 * (yy + zz), 2 * (xy - zw), 2 * (xz + yw), p, pose_shift_x);
        sum_y = row_sum(2 * (xy + zw), one - 2 * (xx + zz), 2 * (yz - xw), p, pose_shift_y);
        sum_z = row_sum(2 * (xz - yw), 2 * (yz + xw), one - 2 * (xx + yy), p, pose_shift_z);
        r.out_x    = clamp_coord(sum_x);
        r.out_y    = clamp_coord(sum_y);
        r.out_z    = clamp_coord(sum_z);
        r.last_out = p.last_in;
        r.overflow = (t_wide'(r.out_x) != sum_x) || (t_wide'(r.out_y) != sum_y)
                  || (t_wide'(r.out_z) != sum_z);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // point driver: offers queued items, predicts each one as it is taken
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_points.push_back(transform_point(i_in_data));
                points_accepted++;
            end
            // valid is only touched while idle or on the edge that took the item
            if (!i_in_valid || o_in_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_in_valid <= 1'b0;
                end else if (idle_enable && $urandom_range(0, 4) == 0) begin
                    send_wait = $urandom_range(0, 2);
                    i_in_valid <= 1'b0;
                end else if (pending_points.size() != 0) begin
                    i_in_data  <= pending_points.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: checks taken items against the oldest prediction and
    // throttles ready, including the long hold asked for by the sequence
    // ------------------------------------------------------------------------
    function automatic void compare_field(input string name, input longint want,
                                          input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_point(input t_point_out got);
        t_point_out want;
        if (expected_points.size() == 0) begin
            $error("result item with no point outstanding: x %0d y %0d z %0d",
                   got.out_x, got.out_y, got.out_z);
            errors++;
            return;
        end
        want = expected_points.pop_front();
        compare_field("out_x", want.out_x, got.out_x);
        compare_field("out_y", want.out_y, got.out_y);
        compare_field("out_z", want.out_z, got.out_z);
        compare_field("last_out", want.last_out, got.last_out);
        compare_field("overflow", want.overflow, got.overflow);
        results_checked++;
        if (want.overflow)
            clamped_results++;
        if (want.last_out)
            lists_closed++;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready)
                check_point(o_out_data);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                ready_wait = HOLD_CYCLES;
            end
            if (ready_wait > 0) begin
                ready_wait--;
                i_out_ready <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 4) == 0) begin
                ready_wait = $urandom_range(0, 2);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // register access and stimulus helpers
    // ------------------------------------------------------------------------

    // setup then access phase; the register takes the value on the access edge
    task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TRANS_X: pose_shift_x = t_coord'(value);
            REG_TRANS_Y: pose_shift_y = t_coord'(value);
            REG_TRANS_Z: pose_shift_z = t_coord'(value);
            REG_QUAT_X:  pose_quat_x  = t_quat'(value[QUAT_W-1:0]);
            REG_QUAT_Y:  pose_quat_y  = t_quat'(value[QUAT_W-1:0]);
            REG_QUAT_Z:  pose_quat_z  = t_quat'(value[QUAT_W-1:0]);
            REG_QUAT_W:  pose_quat_w  = t_quat'(value[QUAT_W-1:0]);
            default: ;  // unmapped address, dropped by the unit
        endcase
    endtask

    task automatic load_pose(input t_coord tx, input t_coord ty, input t_coord tz,
                             input t_quat qx, input t_quat qy, input t_quat qz,
                             input t_quat qw);
        write_register(REG_TRANS_X, tx);
        write_register(REG_TRANS_Y, ty);
        write_register(REG_TRANS_Z, tz);
        write_register(REG_QUAT_X, 32'(qx));
        write_register(REG_QUAT_Y, 32'(qy));
        write_register(REG_QUAT_Z, 32'(qz));
        write_register(REG_QUAT_W, 32'(qw));
        poses_loaded++;
    endtask

    function automatic void queue_point(input t_coord x, input t_coord y, input t_coord z,
                                        input logic last);
        t_point_in p;
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        p.last_in = last;
        pending_points.push_back(p);
    endfunction

    // mostly modest coordinates so that outputs rarely clamp, plus full range
    // and the corner values
    function automatic t_coord pick_coord();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return t_coord'($urandom_range(0, 32'h00FF_FFFF)) - t_coord'(32'h0080_0000);
        if (roll < 9)
            return t_coord'($urandom);
        case ($urandom_range(0, 4))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    function automatic t_coord pick_shift();
        case ($urandom_range(0, 3))
            0: return t_coord'($urandom_range(0, 32'h03FF_FFFF)) - t_coord'(32'h0200_0000);
            1: return t_coord'($urandom);
            2: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            default: return '0;
        endcase
    endfunction

    // style 0: exact turns, 1: any in range, 2: small parts, other: the limits
    function automatic t_quat pick_quat_part(input int style);
        t_quat mag;
        case (style)
            0: case ($urandom_range(0, 3))
                   0: mag = '0;
                   1: mag = 16'sd8192;
                   2: mag = 16'sd11585;
                   default: mag = QUAT_ONE;
               endcase
            1: mag = t_quat'($urandom_range(0, 16384));
            2: mag = t_quat'($urandom_range(0, 1024));
            default: mag = $urandom_range(0, 1) ? QUAT_ONE : t_quat'(0);
        endcase
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    task automatic pick_pose(input int style);
        t_quat qw;
        if (style == 2)
            qw = QUAT_ONE - t_quat'($urandom_range(0, 512));  // close to identity
        else
            qw = pick_quat_part(style);
        load_pose(pick_shift(), pick_shift(), pick_shift(), pick_quat_part(style),
                  pick_quat_part(style), pick_quat_part(style), qw);
    endtask

    // a framed list; now and then the last marks are scrambled as noise
    task automatic queue_list(input int len);
        logic noisy;
        noisy = ($urandom_range(0, 7) == 0);
        for (int n = 0; n < len; n++)
            queue_point(pick_coord(), pick_coord(), pick_coord(),
                        noisy ? ($urandom_range(0, 1) == 1) : (n == len - 1));
    endtask

    // until every queued item is offered, taken and answered, then let the
    // pipeline settle and empty before the registers are touched;
    // judged mid-cycle so that the driver's edge work has settled
    task automatic wait_drained();
        int spent;
        spent = 0;
        @(negedge i_clk);
        while ((pending_points.size() != 0 || i_in_valid || expected_points.size() != 0)
               && spent < DRAIN_LIMIT) begin
            @(negedge i_clk);
            spent++;
        end
        if (spent >= DRAIN_LIMIT) begin
            $error("%0d results never arrived", expected_points.size());
            errors++;
            expected_points.delete();
        end
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        int queued;
        int list_len;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity pose straight out of reset: points pass through unchanged
        queue_point('0, '0, '0, 1'b0);
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        queue_point(-1, 1, 32'sh0001_8000, 1'b1);
        queue_point(32'sh1234_5678, -32'sh0765_4321, COORD_MIN, 1'b1);
        wait_drained();

        // quaternion x at one half mixes y and z; exact halves round up, also for negatives;
        // a write to the spare address must leave the pose alone
        load_pose('0, '0, '0, 16'sd8192, '0, '0, QUAT_ONE);
        write_register(REG_SPARE, $urandom);
        queue_point('0, 1, -1, 1'b0);
        queue_point('0, 3, -3, 1'b1);
        queue_point(COORD_MIN, COORD_MIN, COORD_MAX, 1'b1);
        queue_point(5, -5, 32'sh7FFF_FFFD, 1'b0);
        wait_drained();

        // half turn about x with translation at both ends of its range
        load_pose(COORD_MIN, COORD_MAX, 1, QUAT_ONE, '0, '0, '0);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        queue_point(COORD_MAX, '0, '0, 1'b1);
        queue_point(1, COORD_MAX, COORD_MAX, 1'b0);
        queue_point('0, '0, '0, 1'b1);
        wait_drained();

        // non-unit quaternion at the part limits: strong gain, clamps both ways
        load_pose(COORD_MAX, COORD_MIN, COORD_MAX, -QUAT_ONE, QUAT_ONE, -QUAT_ONE, QUAT_ONE);
        queue_point(COORD_MAX, COORD_MIN, 1, 1'b0);
        queue_point(-1, -1, -1, 1'b1);
        queue_point('0, '0, '0, 1'b0);
        queue_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
        wait_drained();

        // random poses, each followed by framed lists of random points
        for (int phase = 0; phase < RANDOM_POSES; phase++) begin
            // some phases run without gaps, and the closing ones never idle
            idle_enable <= (phase < RANDOM_POSES - 2) && (phase % 4 != 1);
            pick_pose(phase % 4);
            queued = 0;
            while (queued < ITEMS_PER_POSE) begin
                list_len = $urandom_range(1, 16);
                queue_list(list_len);
                // sender stops once, midway, until every prediction so far is answered
                if (phase == 5 && queued < ITEMS_PER_POSE / 2
                    && queued + list_len >= ITEMS_PER_POSE / 2)
                    wait_drained();
                queued = queued + list_len;
            end
            if (phase == 3) begin
                // receiver holds off while a full queue keeps the sender busy,
                // so the pipeline fills and the input side stalls
                @(posedge i_clk);
                hold_requests <= hold_requests + 1;
            end
            wait_drained();
        end

        $display("run covered %0d points under %0d poses, %0d framed lists, %0d clamped",
                 points_accepted, poses_loaded, lists_closed, results_checked == 0 ? 0 :
                 clamped_results);
        $display("included a %0d-cycle receiver hold and a drained sender pause",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("point_rigid_transform_unit_test: clean");
        else
            $display("point_rigid_transform_unit_test: errors");
        $finish;
    end

    // safety net far beyond the slowest correct run
    initial begin
        #(12 * 200000);
        $display("point_rigid_transform_unit_test: errors");
        $finish;
    end

endmodule
